>>> rtl/core/pbd_pkg.sv
// ----------------------------------------------------------------------------
// pbd_pkg
// Shared widths, pipeline stage map, register codes and fixed-point constants
// for the prior box decode pipeline.
// ----------------------------------------------------------------------------
package pbd_pkg;

  // pipeline stage map, one register stage each
  localparam int NUM_STG  = 13;
  localparam int ST_IN    = 0;   // field capture, var * offset, size and center sums
  localparam int ST_MUL   = 1;   // center term product, exp argument times log2(e)
  localparam int ST_P1    = 2;   // first polynomial step, center sum
  localparam int ST_P6    = 7;   // last polynomial step
  localparam int ST_PROD  = 8;   // mantissa times size
  localparam int ST_SHIFT = 9;   // scale by power of two
  localparam int ST_CLAMP = 10;  // half size clamp
  localparam int ST_SUM   = 11;  // corner sums with rounding offset
  localparam int ST_OUT   = 12;  // saturation, output register

  typedef logic [NUM_STG-1:0] stg_en_t;

  // datapath widths
  localparam int CW = 16;        // coordinate / offset field
  localparam int SW = CW + 1;    // prior size and corner sum
  localparam int AW = 33;        // unsigned Q2.14 times signed Q4.12
  localparam int QW = 51;        // Q.38 center and half size
  localparam int PW = 31;        // polynomial accumulator, Q.30

  localparam int IN_TDATA_W  = 8 * CW;
  localparam int OUT_TDATA_W = 4 * CW;
  localparam int CFG_IDX_W   = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VAR_CX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VAR_CY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VAR_W  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VAR_H  = 2'd3;

  localparam logic [CW-1:0] VAR_CX_RST = 16'd1638;
  localparam logic [CW-1:0] VAR_CY_RST = 16'd1638;
  localparam logic [CW-1:0] VAR_W_RST  = 16'd3277;
  localparam logic [CW-1:0] VAR_H_RST  = 16'd3277;

  // log2(e) in Q.30
  localparam logic signed [31:0] LOG2E_Q30 = 32'sd1549082005;
  localparam logic [PW-1:0]      ONE_Q30   = 31'd1073741824;

  // 2^f - 1 Taylor coefficients, Q.30, highest order first, then zero
  localparam logic [PW-1:0] HORNER_C [7] = '{
    31'd165394, 31'd1431680, 31'd10327388, 31'd59597083,
    31'd257941248, 31'd744261118, 31'd0
  };

endpackage

>>> rtl/core/prior_box_decode_unit.sv
// ----------------------------------------------------------------------------
// prior_box_decode_unit
// Center-size box decoding against a prior box, one box per beat, with four
// programmable variances.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tdata: offsets dx dy dw dh, prior l t r b;
//                                     tlast: last box
//  m_*       out  m_tvalid/m_tready  tdata: box left top right bottom;
//                                     tlast: last box
//  cfg_*     in   cfg_we             cfg_index selects variance, cfg_wdata
//
//  Throughput is one box per cycle unless a stall at m_tready holds the pipe;
//  a box passes 13 register stages (input, argument product, six polynomial
//  steps, mantissa product, scale, clamp, corner sum, saturation) to the output.
//  Synchronous reset empties the pipeline and loads the default variances.
//  A stall at m_tready holds only the stages that are full: empty stages
//  downstream still fill, so input beats are taken until the pipe is full.
// ----------------------------------------------------------------------------
module prior_box_decode_unit import pbd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // loc_dx, loc_dy, loc_dw, loc_dh, prior_left, prior_top, prior_right, prior_bottom
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   s_tlast,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // box_left, box_top, box_right, box_bottom
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tlast,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CW-1:0]          cfg_wdata
);

  logic [CW-1:0] var_cx;
  logic [CW-1:0] var_cy;
  logic [CW-1:0] var_w;
  logic [CW-1:0] var_h;

  stg_en_t vld;
  stg_en_t en;
  logic    last_q [NUM_STG];

  logic signed [CW-1:0] loc_dx, loc_dy, loc_dw, loc_dh;
  logic signed [CW-1:0] prior_left, prior_top, prior_right, prior_bottom;

  logic signed [SW-1:0] sum_x, sum_y, size_w, size_h;
  logic signed [AW-1:0] term_x, term_y, term_w, term_h;

  logic signed [QW-1:0] ctr_x, ctr_y, half_w, half_h;
  logic signed [CW-1:0] box_left, box_top, box_right, box_bottom;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      var_cx <= VAR_CX_RST;
      var_cy <= VAR_CY_RST;
      var_w  <= VAR_W_RST;
      var_h  <= VAR_H_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VAR_CX: var_cx <= cfg_wdata;
        REG_VAR_CY: var_cy <= cfg_wdata;
        REG_VAR_W:  var_w  <= cfg_wdata;
        REG_VAR_H:  var_h  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // a stage loads when it or any stage below it up to the output is free
  always_comb begin
    for (int i = 0; i < NUM_STG; i++) begin
      en[i] = m_tready | ~(&(vld | stg_en_t'((1 << i) - 1)));
    end
  end

  assign s_tready = en[ST_IN];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[ST_IN]) begin
        vld[ST_IN] <= s_tvalid;
      end
      for (int i = 1; i < NUM_STG; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_IN]) begin
      last_q[ST_IN] <= s_tlast;
    end
    for (int i = 1; i < NUM_STG; i++) begin
      if (en[i]) begin
        last_q[i] <= last_q[i-1];
      end
    end
  end

  assign loc_dx       = s_tdata[0*CW +: CW];
  assign loc_dy       = s_tdata[1*CW +: CW];
  assign loc_dw       = s_tdata[2*CW +: CW];
  assign loc_dh       = s_tdata[3*CW +: CW];
  assign prior_left   = s_tdata[4*CW +: CW];
  assign prior_top    = s_tdata[5*CW +: CW];
  assign prior_right  = s_tdata[6*CW +: CW];
  assign prior_bottom = s_tdata[7*CW +: CW];

  // input stage: sizes, corner sums and variance * offset
  always_ff @(posedge clk) begin
    if (en[ST_IN]) begin
      size_w <= SW'(prior_right) - SW'(prior_left);
      size_h <= SW'(prior_bottom) - SW'(prior_top);
      sum_x  <= SW'(prior_left) + SW'(prior_right);
      sum_y  <= SW'(prior_top) + SW'(prior_bottom);
      term_x <= $signed({1'b0, var_cx}) * loc_dx;
      term_y <= $signed({1'b0, var_cy}) * loc_dy;
      term_w <= $signed({1'b0, var_w}) * loc_dw;
      term_h <= $signed({1'b0, var_h}) * loc_dh;
    end
  end

  pbd_center u_ctr_x (
    .clk    (clk),
    .en     (en),
    .sum    (sum_x),
    .term   (term_x),
    .size   (size_w),
    .center (ctr_x)
  );

  pbd_center u_ctr_y (
    .clk    (clk),
    .en     (en),
    .sum    (sum_y),
    .term   (term_y),
    .size   (size_h),
    .center (ctr_y)
  );

  pbd_half_size u_half_w (
    .clk  (clk),
    .en   (en),
    .a    (term_w),
    .size (size_w),
    .half (half_w)
  );

  pbd_half_size u_half_h (
    .clk  (clk),
    .en   (en),
    .a    (term_h),
    .size (size_h),
    .half (half_h)
  );

  pbd_corner u_cor_x (
    .clk    (clk),
    .en     (en),
    .center (ctr_x),
    .half   (half_w),
    .lo     (box_left),
    .hi     (box_right)
  );

  pbd_corner u_cor_y (
    .clk    (clk),
    .en     (en),
    .center (ctr_y),
    .half   (half_h),
    .lo     (box_top),
    .hi     (box_bottom)
  );

  assign m_tvalid = vld[ST_OUT];
  assign m_tlast  = last_q[ST_OUT];
  assign m_tdata  = {box_bottom, box_right, box_top, box_left};

  // beats in flight change only by accepted input and taken output
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    !rst |=> $countones(vld) ==
      $past($countones(vld)) + $past(s_tvalid && s_tready) - $past(m_tvalid && m_tready))
    else $error("pipeline occupancy mismatch");

  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> (&en))
    else $error("stage held while output is being taken");

  a_in_free: assert property (@(posedge clk) disable iff (rst)
    !vld[ST_IN] |-> s_tready)
    else $error("empty input stage not ready");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> (vld == '0))
    else $error("pipeline not empty after reset");

endmodule

>>> rtl/core/pbd_center.sv
// ----------------------------------------------------------------------------
// pbd_center
// Decoded center in Q.38: prior center plus variance * offset * size, then
// delayed to line up with the half size path.
// ----------------------------------------------------------------------------
module pbd_center import pbd_pkg::*; (
  input  logic                 clk,
  input  stg_en_t              en,
  input  logic signed [SW-1:0] sum,
  input  logic signed [AW-1:0] term,
  input  logic signed [SW-1:0] size,
  output logic signed [QW-1:0] center
);

  // (a + b) / 2 in Q.12 moved up to Q.38
  localparam int SUM_ALIGN = 25;

  logic signed [AW+SW-1:0] mx;
  logic signed [SW-1:0]    sum_q;
  logic signed [QW-1:0]    cq [ST_P1:ST_CLAMP];

  always_ff @(posedge clk) begin
    if (en[ST_MUL]) begin
      mx    <= term * size;
      sum_q <= sum;
    end
    if (en[ST_P1]) begin
      cq[ST_P1] <= (QW'(sum_q) <<< SUM_ALIGN) + QW'(mx);
    end
    for (int j = ST_P1 + 1; j <= ST_CLAMP; j++) begin
      if (en[j]) begin
        cq[j] <= cq[j-1];
      end
    end
  end

  assign center = cq[ST_CLAMP];

endmodule

>>> rtl/core/pbd_half_size.sv
// ----------------------------------------------------------------------------
// pbd_half_size
// Half of size * exp(variance * offset) in Q.38: base-2 split of the argument,
// six-step polynomial for the fraction, mantissa product, power-of-two scale
// and clamp to +/-2^49.
// ----------------------------------------------------------------------------
module pbd_half_size import pbd_pkg::*; (
  input  logic                 clk,
  input  stg_en_t              en,
  input  logic signed [AW-1:0] a,
  input  logic signed [SW-1:0] size,
  output logic signed [QW-1:0] half
);

  localparam int TW         = 24;        // argument in Q.16
  localparam int FW         = 16;        // fraction bits
  localparam int KW         = TW - FW;   // integer exponent
  localparam int SHW        = KW + 1;    // exponent less bias
  localparam int PRW        = 48;        // mantissa times size, Q.42
  localparam int XW         = 90;        // left-scaled product, up to 2^88 in magnitude
  localparam int HALF_SHIFT = 5;         // Q.42 to Q.38 and the halving

  localparam logic signed [QW-1:0] HALF_MAX = QW'(1) << (QW - 2);

  logic signed [63:0]     targ_c;
  logic signed [TW-1:0]   tt;
  logic [FW-1:0]          f_q    [ST_P1:ST_P6-1];
  logic signed [KW-1:0]   k_q    [ST_P1:ST_SHIFT-1];
  logic signed [SW-1:0]   size_q [ST_MUL:ST_PROD-1];
  logic [PW-1:0]          pq     [ST_P1:ST_P6];
  logic [PW-1:0]          mant_c;
  logic signed [PRW-1:0]  prod;
  logic signed [SHW-1:0]  sexp_c;
  logic signed [SHW-1:0]  rsh_c;
  logic signed [XW-1:0]   scaled_c;
  logic signed [XW-1:0]   scaled;
  logic                   pos_ovf_c;
  logic                   neg_ovf_c;

  assign targ_c = a * LOG2E_Q30;

  always_ff @(posedge clk) begin
    if (en[ST_MUL]) begin
      tt             <= targ_c[63:40];
      size_q[ST_MUL] <= size;
    end
    if (en[ST_P1]) begin
      f_q[ST_P1] <= tt[FW-1:0];
      k_q[ST_P1] <= tt[TW-1:FW];
    end
    for (int j = ST_P1 + 1; j < ST_P6; j++) begin
      if (en[j]) begin
        f_q[j] <= f_q[j-1];
      end
    end
    for (int j = ST_P1 + 1; j < ST_SHIFT; j++) begin
      if (en[j]) begin
        k_q[j] <= k_q[j-1];
      end
    end
    for (int j = ST_MUL + 1; j < ST_PROD; j++) begin
      if (en[j]) begin
        size_q[j] <= size_q[j-1];
      end
    end
  end

  // horner steps: p = c + floor(p * f / 2^16)
  for (genvar j = ST_P1; j <= ST_P6; j++) begin : g_horner
    logic [PW-1:0]    prev;
    logic [FW-1:0]    fx;
    logic [PW+FW-1:0] prd;
    if (j == ST_P1) begin : g_first
      assign prev = HORNER_C[0];
      assign fx   = tt[FW-1:0];
    end else begin : g_rest
      assign prev = pq[j-1];
      assign fx   = f_q[j-1];
    end
    assign prd = prev * fx;
    always_ff @(posedge clk) begin
      if (en[j]) begin
        pq[j] <= HORNER_C[j-ST_P1+1] + prd[PW+FW-1:FW];
      end
    end
  end

  assign mant_c = ONE_Q30 + pq[ST_P6];

  always_ff @(posedge clk) begin
    if (en[ST_PROD]) begin
      prod <= $signed({1'b0, mant_c}) * size_q[ST_PROD-1];
    end
  end

  assign sexp_c = {k_q[ST_SHIFT-1][KW-1], k_q[ST_SHIFT-1]} - SHW'(HALF_SHIFT);
  assign rsh_c  = -sexp_c;

  always_comb begin
    if (!sexp_c[SHW-1] && sexp_c != '0) begin
      scaled_c = XW'(prod) <<< sexp_c[SHW-2:0];
    end else begin
      scaled_c = XW'(prod >>> rsh_c[SHW-2:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_SHIFT]) begin
      scaled <= scaled_c;
    end
  end

  // magnitude at or above 2^49 clamps, sign kept
  assign pos_ovf_c = !scaled[XW-1] && (|scaled[XW-2:QW-2]);
  assign neg_ovf_c = scaled[XW-1] && !(&scaled[XW-2:QW-2]);

  always_ff @(posedge clk) begin
    if (en[ST_CLAMP]) begin
      if (pos_ovf_c) begin
        half <= HALF_MAX;
      end else if (neg_ovf_c) begin
        half <= -HALF_MAX;
      end else begin
        half <= scaled[QW-1:0];
      end
    end
  end

endmodule

>>> rtl/core/pbd_corner.sv
// ----------------------------------------------------------------------------
// pbd_corner
// Both corners of one axis: center -/+ half size, rounded half up from Q.38
// to Q.12 and saturated to 16 bits.
// ----------------------------------------------------------------------------
module pbd_corner import pbd_pkg::*; (
  input  logic                 clk,
  input  stg_en_t              en,
  input  logic signed [QW-1:0] center,
  input  logic signed [QW-1:0] half,
  output logic signed [CW-1:0] lo,
  output logic signed [CW-1:0] hi
);

  localparam int SUMW  = QW + 1;
  localparam int FRAC  = 26;
  localparam int RW    = SUMW - FRAC;

  localparam logic signed [SUMW-1:0] RND  = SUMW'(1) <<< (FRAC - 1);
  localparam logic signed [RW-1:0]   QMAX = RW'(32767);
  localparam logic signed [RW-1:0]   QMIN = RW'(-32768);

  logic signed [SUMW-1:0] lo_sum;
  logic signed [SUMW-1:0] hi_sum;

  function automatic logic signed [CW-1:0] to_q12(input logic signed [SUMW-1:0] v);
    logic signed [RW-1:0] r;
    r = v[SUMW-1:FRAC];
    if (r > QMAX) begin
      return QMAX[CW-1:0];
    end else if (r < QMIN) begin
      return QMIN[CW-1:0];
    end
    return r[CW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en[ST_SUM]) begin
      lo_sum <= SUMW'(center) - SUMW'(half) + RND;
      hi_sum <= SUMW'(center) + SUMW'(half) + RND;
    end
    if (en[ST_OUT]) begin
      lo <= to_q12(lo_sum);
      hi <= to_q12(hi_sum);
    end
  end

endmodule

>>> dv/box_decode_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_decode_checker
// Watches the box stream, the result stream and the variance writes of the
// prior box decoder. It predicts every decoded box in fixed point and checks
// each result beat, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module box_decode_checker import pbd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  // loc_dx, loc_dy, loc_dw, loc_dh, prior_left, prior_top, prior_right, prior_bottom
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   s_tlast,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  // box_left, box_top, box_right, box_bottom
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   m_tlast,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CW-1:0]          cfg_wdata,
  output int                     mismatches,
  output int                     outstanding
);

  localparam longint LOG2E_FIX = 64'sd1549082005;  // log2(e), Q.30
  localparam longint HALF_LIMIT = 64'sd1 <<< 49;    // 2^11 in Q.38
  localparam longint unsigned MANT_ONE = 64'd1 << 30;

  typedef struct packed {
    logic [3:0][CW-1:0] corner;
    logic               last;
  } box_t;

  box_t   decoded_boxes [$];
  longint gain_cx, gain_cy, gain_w, gain_h;
  string  corner_name [4] = '{"box_left", "box_top", "box_right", "box_bottom"};

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t box mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // half of size * exp(gain * off), Q.38
  function automatic longint half_extent(input longint gain, input longint off,
                                         input longint size);
    longint arg, lg, k, sh, prod;
    longint unsigned frac, acc, mag;
    arg = gain * off;
    lg = (arg * LOG2E_FIX) >>> 40;
    k = lg >>> 16;
    frac = longint'(lg & 64'hFFFF) << 14;
    // 2^frac - 1 by horner, each product floored to Q.30
    acc = 165394;
    acc = 64'd1431680 + ((acc * frac) >> 30);
    acc = 64'd10327388 + ((acc * frac) >> 30);
    acc = 64'd59597083 + ((acc * frac) >> 30);
    acc = 64'd257941248 + ((acc * frac) >> 30);
    acc = 64'd744261118 + ((acc * frac) >> 30);
    acc = (acc * frac) >> 30;
    prod = longint'(MANT_ONE + acc) * size;
    sh = k - 5;
    if (sh <= 0) begin
      if (-sh > 63) return prod >>> 63;
      return prod >>> (-sh);
    end
    if (prod == 0) return 0;
    mag = (prod < 0) ? longint'(-prod) : prod;
    if (sh >= 50 || mag >= longint'(HALF_LIMIT >>> sh))
      return (prod < 0) ? -HALF_LIMIT : HALF_LIMIT;
    return prod <<< sh;
  endfunction

  function automatic logic [CW-1:0] round_sat(input longint v);
    longint r;
    r = (v + (64'sd1 <<< 25)) >>> 26;
    if (r > 32767) r = 32767;
    else if (r < -32768) r = -32768;
    return r[CW-1:0];
  endfunction

  function automatic box_t decode_box(input logic [IN_TDATA_W-1:0] d, input logic last);
    longint dx, dy, dw, dh, lo_x, lo_y, hi_x, hi_y, w, h, cx, cy, hw, hh;
    box_t b;
    dx = $signed(d[0*CW +: CW]);
    dy = $signed(d[1*CW +: CW]);
    dw = $signed(d[2*CW +: CW]);
    dh = $signed(d[3*CW +: CW]);
    lo_x = $signed(d[4*CW +: CW]);
    lo_y = $signed(d[5*CW +: CW]);
    hi_x = $signed(d[6*CW +: CW]);
    hi_y = $signed(d[7*CW +: CW]);
    // inverted priors just give a negative size
    w = hi_x - lo_x;
    h = hi_y - lo_y;
    cx = (lo_x + hi_x) * (64'sd1 <<< 25) + gain_cx * dx * w;
    cy = (lo_y + hi_y) * (64'sd1 <<< 25) + gain_cy * dy * h;
    hw = half_extent(gain_w, dw, w);
    hh = half_extent(gain_h, dh, h);
    b.corner[0] = round_sat(cx - hw);
    b.corner[1] = round_sat(cy - hh);
    b.corner[2] = round_sat(cx + hw);
    b.corner[3] = round_sat(cy + hh);
    b.last = last;
    return b;
  endfunction

  always @(posedge clk) begin
    box_t want;
    if (rst) begin
      gain_cx = VAR_CX_RST;
      gain_cy = VAR_CY_RST;
      gain_w  = VAR_W_RST;
      gain_h  = VAR_H_RST;
      decoded_boxes.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (decoded_boxes.size() == 0) begin
          report_mismatch("beat with nothing pending, box_left", $signed(m_tdata[CW-1:0]), 0);
        end else begin
          want = decoded_boxes.pop_front();
          for (int i = 0; i < 4; i++)
            if (m_tdata[i*CW +: CW] !== want.corner[i])
              report_mismatch(corner_name[i], $signed(m_tdata[i*CW +: CW]),
                              $signed(want.corner[i]));
          if (m_tlast !== want.last)
            report_mismatch("last_out", m_tlast, want.last);
        end
      end
      // predict with the variances in force before any write at this edge
      if (s_tvalid && s_tready)
        decoded_boxes.push_back(decode_box(s_tdata, s_tlast));
      if (cfg_we) begin
        case (cfg_index)
          REG_VAR_CX: gain_cx = cfg_wdata;
          REG_VAR_CY: gain_cy = cfg_wdata;
          REG_VAR_W:  gain_w  = cfg_wdata;
          REG_VAR_H:  gain_h  = cfg_wdata;
          default: ;
        endcase
      end
    end
    outstanding <= decoded_boxes.size();
  end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the prior box decoder. Drives directed corner
// boxes and random priors under several variance settings, with random idle
// cycles on both streams save the last phase; the checker beside the block compares.
// ----------------------------------------------------------------------------
module testbench;
  import pbd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // loc_dx, loc_dy, loc_dw, loc_dh, prior_left, prior_top, prior_right, prior_bottom
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tlast = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // box_left, box_top, box_right, box_bottom
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_VAR_CX;
  logic [CW-1:0]          cfg_wdata = '0;

  int mismatches;
  int outstanding;
  int send_idle = 20;
  int recv_idle = 54;
  int cycles = 0;

  prior_box_decode_unit u_top (.*);

  box_decode_checker u_checker (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_idle);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[prior_box_decode_unit] ERROR");
      $finish;
    end
  end

  function automatic logic [IN_TDATA_W-1:0] box_beat(
      input logic [CW-1:0] dx, dy, dw, dh, l, t, r, b);
    return {b, r, t, l, dh, dw, dy, dx};
  endfunction

  function automatic logic [CW-1:0] extreme_value();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      4: return 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  // valid stays high between back-to-back beats, dropped only for idle cycles
  task automatic send_box(input logic [IN_TDATA_W-1:0] beat, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= beat;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // hold off until every pending box is out, then let the pipe go quiet
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input logic [CW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic load_gains(input logic [CW-1:0] cx, cy, w, h);
    write_gain(REG_VAR_CX, cx);
    write_gain(REG_VAR_CY, cy);
    write_gain(REG_VAR_W, w);
    write_gain(REG_VAR_H, h);
  endtask

  task automatic send_directed();
    send_box(box_beat(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                      16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b0);
    send_box(box_beat(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                      16'h0000, 16'h0000, 16'h1000, 16'h1000), 1'b0);
    send_box(box_beat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                      16'h0000, 16'h0000, 16'h1000, 16'h1000), 1'b0);
    send_box(box_beat(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                      16'h0000, 16'h0000, 16'h1000, 16'h1000), 1'b1);
    // widest prior the fields allow
    send_box(box_beat(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                      16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF), 1'b0);
    send_box(box_beat(16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF,
                      16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF), 1'b0);
    // inverted priors
    send_box(box_beat(16'h8000, 16'h7FFF, 16'h8000, 16'h8000,
                      16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000), 1'b0);
    send_box(box_beat(16'h1000, 16'hF000, 16'h1000, 16'hF000,
                      16'h1000, 16'h1000, 16'h0000, 16'h0000), 1'b1);
    send_box(box_beat(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                      16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1);
    send_box(box_beat(16'h0001, 16'h0001, 16'h0001, 16'h0001,
                      16'h0001, 16'h0001, 16'h0001, 16'h0001), 1'b0);
    // tiny prior with a huge log-size offset
    send_box(box_beat(16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF,
                      16'h0800, 16'h0800, 16'h0801, 16'h0801), 1'b0);
    send_box(box_beat(16'h1000, 16'h0800, 16'hF000, 16'h0800,
                      16'h0000, 16'h0400, 16'h1000, 16'h0C00), 1'b1);
    send_box(box_beat(16'h4000, 16'hC000, 16'h3000, 16'hD000,
                      16'h0400, 16'h0800, 16'h0C00, 16'h1000), 1'b0);
  endtask

  task automatic send_random(input int count);
    logic [7:0][CW-1:0] fld;
    int pick, lo, span;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        // plausible prior inside the unit square, offsets within +/-2
        for (int i = 0; i < 4; i++) fld[i] = 16'($urandom_range(16383)) - 16'd8192;
        for (int a = 0; a < 2; a++) begin
          lo = $urandom_range(3900);
          span = $urandom_range(4096 - lo, 1);
          fld[4+a] = 16'(lo);
          fld[6+a] = 16'(lo + span);
        end
      end else if (pick < 85) begin
        for (int i = 0; i < 8; i++) fld[i] = 16'($urandom);
      end else begin
        for (int i = 0; i < 8; i++) fld[i] = extreme_value();
      end
      send_box(fld, $urandom_range(15) == 0);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_directed();
    send_random(340);
    settle();

    load_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_directed();
    send_random(50);
    settle();

    send_idle = 54;
    recv_idle = 20;
    load_gains(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_random(60);
    settle();

    load_gains(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    send_random(330);
    settle();

    send_idle = 0;
    recv_idle = 0;
    load_gains(16'h0000, 16'hFFFF, 16'($urandom), VAR_CX_RST);
    send_random(230);
    settle();

    if (mismatches == 0)
      $display("[prior_box_decode_unit] OK");
    else
      $display("[prior_box_decode_unit] ERROR");
    $finish;
  end

endmodule

>>> files.f
rtl/core/pbd_pkg.sv
rtl/core/pbd_center.sv
rtl/core/pbd_half_size.sv
rtl/core/pbd_corner.sv
rtl/core/prior_box_decode_unit.sv
dv/box_decode_checker.sv
dv/testbench.sv
